// ===== src/egbr_pkg.sv =====
// Shared types, codes and constants of the Exp-Golomb bitstream reader.
package egbr_pkg;

  // Default buffer size in bytes
  localparam int BUFFER_BYTES_DEF = 4096;

  // Longest fixed field and longest ue zero prefix
  localparam logic [5:0] MAX_FIELD_BITS = 6'd32;
  localparam logic [5:0] UE_MAX_ZEROS   = 6'd31;

  // Field widths of the request and result channels
  localparam int ACTION_W = 3;
  localparam int INDEX_W  = 12;
  localparam int BYTE_W   = 8;
  localparam int BIT_W    = 3;
  localparam int COUNT_W  = 6;
  localparam int VALUE_W  = 33;
  localparam int STATUS_W = 2;
  localparam int CURSOR_W = 13;
  localparam int ACC_W    = 32;

  // Request actions
  localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_SET   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_FIXED = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_UE    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_SE    = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PAST_END    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LONG_PREFIX = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_BITS,
    S_FINISH
  } state_e;

  // Kind of field being read
  typedef enum logic [1:0] {
    M_FIXED,
    M_UE,
    M_SE
  } mode_e;

  // Commands from the sequencer to the shift/accumulate unit
  typedef struct packed {
    logic clear;
    logic shift;
    logic zero_inc;
    logic bit_in;
  } acc_cmd_t;

endpackage

// ===== src/egbr_if.sv =====
// Request and result channel interfaces of the Exp-Golomb bitstream reader.
interface egbr_req_if import egbr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [INDEX_W-1:0]  byte_index;
  logic [BYTE_W-1:0]   byte_value;
  logic [BIT_W-1:0]    bit_index;
  logic [COUNT_W-1:0]  bit_count;

  modport source (output valid, action, byte_index, byte_value, bit_index, bit_count,
                  input ready);
  modport sink   (input valid, action, byte_index, byte_value, bit_index, bit_count,
                  output ready);
endinterface

interface egbr_res_if import egbr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  field_value;
  logic [STATUS_W-1:0]        status;
  logic [CURSOR_W-1:0]        cursor_byte;
  logic [BIT_W-1:0]           cursor_bit;

  modport source (output valid, field_value, status, cursor_byte, cursor_bit,
                  input ready);
  modport sink   (input valid, field_value, status, cursor_byte, cursor_bit,
                  output ready);
endinterface

// ===== src/egbr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module egbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/egbr_acc.sv =====
// Shift/accumulate unit: gathers field bits, counts ue prefix zeros, forms the value.
module egbr_acc import egbr_pkg::*; (
  input  logic                      clk_i,
  input  acc_cmd_t                  cmd_i,
  input  mode_e                     mode_i,
  output logic [COUNT_W-1:0]        zeros_o,
  output logic signed [VALUE_W-1:0] value_o
);

  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [COUNT_W-1:0] zeros_q, zeros_d;
  logic [VALUE_W-1:0] lead;
  logic [VALUE_W-1:0] half;

  // Accumulator and zero counter updates
  always_comb begin
    acc_d   = acc_q;
    zeros_d = zeros_q;
    if (cmd_i.clear) begin
      acc_d   = '0;
      zeros_d = '0;
    end else begin
      if (cmd_i.shift) begin
        acc_d = {acc_q[ACC_W-2:0], cmd_i.bit_in};
      end
      if (cmd_i.zero_inc) begin
        zeros_d = zeros_q + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    zeros_q <= zeros_d;
  end

  // ue value is (2^zeros | suffix) - 1; se magnitude is that sum halved
  assign lead = VALUE_W'(acc_q) | (VALUE_W'(1) << zeros_q);
  assign half = lead >> 1;

  always_comb begin
    case (mode_i)
      M_UE:    value_o = $signed(lead - VALUE_W'(1));
      M_SE:    value_o = lead[0] ? $signed(VALUE_W'(0) - half) : $signed(half);
      default: value_o = $signed(VALUE_W'(acc_q));
    endcase
  end

  assign zeros_o = zeros_q;

endmodule

// ===== src/exp_golomb_bitstream_reader_unit.sv =====
// Exp-Golomb bitstream reader: byte buffer, bit cursor and field read sequencer.
//
// Usage: requests arrive on req_i (valid/ready). A write stores one byte and a
// set moves the cursor; both give no result. Fixed, ue and se reads each give
// one result on res_o with the value, a status and the cursor after the read.
// Unknown actions are dropped.
// A read walks the buffer one bit per cycle through a shared shift/accumulate
// unit; each buffer byte touched adds a RAM fetch step, and a finish step
// follows. Reads that fail the end-of-buffer check up front go straight to
// the finish step.
// The request side is ready only while the sequencer is idle. A finished
// result sits in an output register; if the receiver stalls, the next read
// waits in its finish step until that register is free, and no requests are
// taken meanwhile.
// Reset clears the cursor to byte 0, bit 0 and empties the output register.
// Buffer contents are undefined until written; no clearing pass is run.
module exp_golomb_bitstream_reader_unit import egbr_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  egbr_req_if.sink    req_i,
  egbr_res_if.source  res_o
);

  localparam int AW        = $clog2(BUFFER_BYTES);
  localparam int CBW       = $clog2(BUFFER_BYTES + 1);
  localparam int PW        = CBW + 3;
  localparam int TotalBits = BUFFER_BYTES * 8;
  localparam logic [PW:0]    TOTAL_EXT = TotalBits[PW:0];
  localparam logic [31:0]    BUF_LIMIT = 32'(BUFFER_BYTES);
  localparam logic [CBW-1:0] END_BYTE  = BUFFER_BYTES[CBW-1:0];

  state_e              state_q, state_d;
  mode_e               mode_q, mode_d;
  logic                prefix_q, prefix_d;
  logic [COUNT_W-1:0]  remain_q, remain_d;
  logic [PW-1:0]       pos_q, pos_d;
  logic [PW-1:0]       cur_q, cur_d;
  logic [STATUS_W-1:0] status_q, status_d;

  logic                       out_valid_q, out_valid_d;
  logic signed [VALUE_W-1:0]  out_value_q, out_value_d;
  logic [STATUS_W-1:0]        out_status_q, out_status_d;
  logic [PW-1:0]              out_cur_q, out_cur_d;

  acc_cmd_t                  acc_cmd;
  logic [COUNT_W-1:0]        zeros;
  logic signed [VALUE_W-1:0] acc_value;

  logic               ram_we;
  logic               ram_re;
  logic [BYTE_W-1:0]  ram_rdata;

  logic               in_fire;
  logic               is_read;
  logic               idx_in_range;
  logic [COUNT_W-1:0] n_clamp;
  logic               fix_over;
  logic               cur_at_end;
  logic               bit_cur;
  logic [PW-1:0]      pos_inc;
  logic               suf_over;
  logic               next_end;
  logic               byte_done;
  logic               long_prefix;
  logic               out_free;

  // Shared condition terms
  assign in_fire      = req_i.valid && req_i.ready;
  assign is_read      = (req_i.action == ACT_FIXED) || (req_i.action == ACT_UE) ||
                        (req_i.action == ACT_SE);
  assign idx_in_range = 32'(req_i.byte_index) < BUF_LIMIT;
  assign n_clamp      = (req_i.bit_count > MAX_FIELD_BITS) ? MAX_FIELD_BITS
                                                           : req_i.bit_count;
  assign fix_over     = ({1'b0, cur_q} + (PW+1)'(n_clamp)) > TOTAL_EXT;
  assign cur_at_end   = {1'b0, cur_q} >= TOTAL_EXT;
  assign bit_cur      = ram_rdata[~pos_q[2:0]];
  assign pos_inc      = pos_q + PW'(1);
  assign suf_over     = ({1'b0, pos_inc} + (PW+1)'(zeros)) > TOTAL_EXT;
  assign next_end     = {1'b0, pos_inc} >= TOTAL_EXT;
  assign byte_done    = pos_inc[2:0] == 3'd0;
  assign long_prefix  = (zeros == UE_MAX_ZEROS) && !bit_cur;
  assign out_free     = !out_valid_q || res_o.ready;

  // Buffer memory
  assign ram_we = in_fire && (req_i.action == ACT_WRITE) && idx_in_range;
  assign ram_re = state_q == S_FETCH;

  egbr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(req_i.byte_index)),
    .wdata_i (req_i.byte_value),
    .re_i    (ram_re),
    .raddr_i (pos_q[AW+2:3]),
    .rdata_o (ram_rdata)
  );

  // Shift/accumulate unit
  egbr_acc u_acc (
    .clk_i   (clk_i),
    .cmd_i   (acc_cmd),
    .mode_i  (mode_q),
    .zeros_o (zeros),
    .value_o (acc_value)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (req_i.action == ACT_FIXED) begin
            state_d = (fix_over || (n_clamp == '0)) ? S_FINISH : S_FETCH;
          end else if ((req_i.action == ACT_UE) || (req_i.action == ACT_SE)) begin
            state_d = cur_at_end ? S_FINISH : S_FETCH;
          end
        end
      end
      S_FETCH: state_d = S_BITS;
      S_BITS: begin
        if (prefix_q) begin
          if (bit_cur) begin
            if (suf_over || (zeros == '0)) begin
              state_d = S_FINISH;
            end else if (byte_done) begin
              state_d = S_FETCH;
            end
          end else if (long_prefix || next_end) begin
            state_d = S_FINISH;
          end else if (byte_done) begin
            state_d = S_FETCH;
          end
        end else if (remain_q == COUNT_W'(1)) begin
          state_d = S_FINISH;
        end else if (byte_done) begin
          state_d = S_FETCH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs and datapath updates
  always_comb begin
    mode_d       = mode_q;
    prefix_d     = prefix_q;
    remain_d     = remain_q;
    pos_d        = pos_q;
    cur_d        = cur_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_cur_d    = out_cur_q;
    acc_cmd      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (req_i.action == ACT_SET) begin
            cur_d = idx_in_range ? {CBW'(req_i.byte_index), req_i.bit_index}
                                 : {END_BYTE, 3'd0};
          end
          if (is_read) begin
            acc_cmd.clear = 1'b1;
            pos_d         = cur_q;
            status_d      = ST_OK;
            if (req_i.action == ACT_FIXED) begin
              mode_d   = M_FIXED;
              prefix_d = 1'b0;
              remain_d = n_clamp;
              if (fix_over) begin
                status_d = ST_PAST_END;
              end
            end else begin
              mode_d   = (req_i.action == ACT_SE) ? M_SE : M_UE;
              prefix_d = 1'b1;
              if (cur_at_end) begin
                status_d = ST_PAST_END;
              end
            end
          end
        end
      end
      S_FETCH: ;
      S_BITS: begin
        pos_d = pos_inc;
        if (prefix_q) begin
          if (bit_cur) begin
            prefix_d = 1'b0;
            remain_d = zeros;
            if (suf_over) begin
              status_d = ST_PAST_END;
            end
          end else begin
            acc_cmd.zero_inc = 1'b1;
            if (long_prefix) begin
              status_d = ST_LONG_PREFIX;
            end else if (next_end) begin
              status_d = ST_PAST_END;
            end
          end
        end else begin
          acc_cmd.shift  = 1'b1;
          acc_cmd.bit_in = bit_cur;
          remain_d       = remain_q - COUNT_W'(1);
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          if (status_q == ST_OK) begin
            out_value_d = acc_value;
            out_cur_d   = pos_q;
            cur_d       = pos_q;
          end else begin
            out_value_d = '0;
            out_cur_d   = cur_q;
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    prefix_q     <= prefix_d;
    remain_q     <= remain_d;
    pos_q        <= pos_d;
    status_q     <= status_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_cur_q    <= out_cur_d;
  end

  // Channel outputs
  assign req_i.ready       = state_q == S_IDLE;
  assign res_o.valid       = out_valid_q;
  assign res_o.field_value = out_value_q;
  assign res_o.status      = out_status_q;
  assign res_o.cursor_byte = CURSOR_W'(out_cur_q[PW-1:3]);
  assign res_o.cursor_bit  = out_cur_q[2:0];

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench of the Exp-Golomb bitstream reader: directed table, then random requests.
`timescale 1ns / 100ps

module tb import egbr_pkg::*; ();

  localparam int BUF_BYTES    = BUFFER_BYTES_DEF;
  localparam int TOTAL_BITS   = BUF_BYTES * 8;
  localparam int ITEM_GOAL    = 950;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 1_000_000;

  // Action code the block must drop
  localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 3'd7;

  // Idle percentages per phase: none, sender, receiver, both
  localparam int PHASE_IDLE  [4] = '{0, 54, 0, 19};
  localparam int PHASE_STALL [4] = '{0, 0, 54, 19};

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  byte_index;
    logic [BYTE_W-1:0]   byte_value;
    logic [BIT_W-1:0]    bit_index;
    logic [COUNT_W-1:0]  bit_count;
  } request_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] field_value;
    logic [STATUS_W-1:0]       status;
    logic [CURSOR_W-1:0]       cursor_byte;
    logic [BIT_W-1:0]          cursor_bit;
  } field_result_t;

  typedef struct packed {
    request_t      req;
    logic          typed;
    field_result_t want;
  } table_row_t;

  localparam field_result_t NO_RESULT = '0;

  // Directed requests; rows with typed set carry their expected result
  localparam table_row_t DIRECTED_ROWS [25] = '{
    '{'{ACT_WRITE,   12'd4,    8'h00, 3'd0, 6'd0 }, 1'b0, NO_RESULT},
    '{'{ACT_WRITE,   12'd5,    8'h00, 3'd0, 6'd0 }, 1'b0, NO_RESULT},
    '{'{ACT_WRITE,   12'd6,    8'h00, 3'd0, 6'd0 }, 1'b0, NO_RESULT},
    '{'{ACT_WRITE,   12'd7,    8'h00, 3'd0, 6'd0 }, 1'b0, NO_RESULT},
    '{'{ACT_WRITE,   12'd8,    8'h01, 3'd0, 6'd0 }, 1'b0, NO_RESULT},
    '{'{ACT_WRITE,   12'd9,    8'hFF, 3'd0, 6'd0 }, 1'b0, NO_RESULT},
    '{'{ACT_WRITE,   12'd10,   8'hFF, 3'd0, 6'd0 }, 1'b0, NO_RESULT},
    '{'{ACT_WRITE,   12'd11,   8'hFF, 3'd0, 6'd0 }, 1'b0, NO_RESULT},
    '{'{ACT_WRITE,   12'd12,   8'hFF, 3'd0, 6'd0 }, 1'b0, NO_RESULT},
    // 32 zeros: prefix too long, cursor stays
    '{'{ACT_SET,     12'd4,    8'h00, 3'd0, 6'd0 }, 1'b0, NO_RESULT},
    '{'{ACT_UE,      12'd0,    8'h00, 3'd0, 6'd0 }, 1'b1,
      '{33'h0, ST_LONG_PREFIX, 13'd4, 3'd0}},
    '{'{ACT_FIXED,   12'd0,    8'h00, 3'd0, 6'd0 }, 1'b1, '{33'h0, ST_OK, 13'd4, 3'd0}},
    // 31 zeros and an all-ones suffix: largest ue
    '{'{ACT_SET,     12'd5,    8'h00, 3'd0, 6'd0 }, 1'b0, NO_RESULT},
    '{'{ACT_UE,      12'd0,    8'h00, 3'd0, 6'd0 }, 1'b1,
      '{33'h0_FFFF_FFFE, ST_OK, 13'd12, 3'd7}},
    // count above the field limit is clipped
    '{'{ACT_SET,     12'd8,    8'h00, 3'd0, 6'd0 }, 1'b0, NO_RESULT},
    '{'{ACT_FIXED,   12'd0,    8'h00, 3'd0, 6'd63}, 1'b0, NO_RESULT},
    '{'{ACT_SET,     12'd9,    8'h00, 3'd0, 6'd0 }, 1'b0, NO_RESULT},
    '{'{ACT_FIXED,   12'd0,    8'h00, 3'd0, 6'd32}, 1'b1,
      '{33'h0_FFFF_FFFF, ST_OK, 13'd13, 3'd0}},
    '{'{ACT_UNKNOWN, 12'hFFF,  8'hFF, 3'd7, 6'd63}, 1'b0, NO_RESULT},
    // last byte of the buffer, reads running off the end
    '{'{ACT_WRITE,   12'd4095, 8'h81, 3'd0, 6'd0 }, 1'b0, NO_RESULT},
    '{'{ACT_SET,     12'd4095, 8'h00, 3'd0, 6'd0 }, 1'b0, NO_RESULT},
    '{'{ACT_UE,      12'd0,    8'h00, 3'd0, 6'd0 }, 1'b1, '{33'h0, ST_OK, 13'd4095, 3'd1}},
    '{'{ACT_SE,      12'd0,    8'h00, 3'd0, 6'd0 }, 1'b1,
      '{33'h0, ST_PAST_END, 13'd4095, 3'd1}},
    '{'{ACT_FIXED,   12'd0,    8'h00, 3'd0, 6'd8 }, 1'b1,
      '{33'h0, ST_PAST_END, 13'd4095, 3'd1}},
    '{'{ACT_FIXED,   12'd0,    8'h00, 3'd0, 6'd7 }, 1'b1, '{33'h1, ST_OK, 13'd4096, 3'd0}}
  };

  logic clk_i;
  logic rst_ni;

  egbr_req_if req_if ();
  egbr_res_if res_if ();

  exp_golomb_bitstream_reader_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  // Shadow copy of the buffer and cursor
  logic [BYTE_W-1:0]   stream_mem   [BUF_BYTES] = '{default: '0};
  bit                  byte_written [BUF_BYTES];
  logic [CURSOR_W-1:0] cur_byte_q = '0;
  logic [BIT_W-1:0]    cur_bit_q  = '0;

  field_result_t pending_fields [$];
  int items_sent     = 0;
  int mismatch_count = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int sink_hold_left = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Stream bit at a bit position; notes the first byte read that was never written
  function automatic logic stream_bit(input int pos, inout int missing);
    int idx;
    idx = pos >> 3;
    if (idx >= BUF_BYTES) return 1'b0;
    if (!byte_written[idx] && missing < 0) missing = idx;
    return stream_mem[idx][7 - (pos & 7)];
  endfunction

  // Works out the result of one request; state changes only when commit is set.
  // Returns 1 when the request gives a result.
  function automatic bit decode_request(input request_t r, input bit commit,
                                        output field_result_t res, output int missing);
    int start, pos, n, zeros, i;
    logic [VALUE_W-1:0]  val, mag;
    logic [STATUS_W-1:0] st;
    logic one_seen;
    missing = -1;
    res = '0;
    start = int'(cur_byte_q) * 8 + int'(cur_bit_q);
    pos = start;
    val = '0;
    st = ST_OK;
    case (r.action)
      ACT_WRITE: begin
        if (commit && r.byte_index < BUF_BYTES) begin
          stream_mem[r.byte_index] = r.byte_value;
          byte_written[r.byte_index] = 1'b1;
        end
        return 1'b0;
      end
      ACT_SET: begin
        if (commit) begin
          if (r.byte_index < BUF_BYTES) begin
            cur_byte_q = CURSOR_W'(r.byte_index);
            cur_bit_q  = r.bit_index;
          end else begin
            cur_byte_q = CURSOR_W'(BUF_BYTES);
            cur_bit_q  = '0;
          end
        end
        return 1'b0;
      end
      ACT_FIXED: begin
        // keep the byte under the cursor defined even for an empty read
        void'(stream_bit(start, missing));
        n = (r.bit_count > MAX_FIELD_BITS) ? int'(MAX_FIELD_BITS) : int'(r.bit_count);
        if (pos + n > TOTAL_BITS) begin
          st = ST_PAST_END;
        end else begin
          for (i = 0; i < n; i++) begin
            val = {val[VALUE_W-2:0], stream_bit(pos, missing)};
            pos++;
          end
        end
      end
      ACT_UE, ACT_SE: begin
        void'(stream_bit(start, missing));
        // zero prefix, checked bit by bit against the buffer end
        zeros = 0;
        one_seen = 1'b0;
        while (!one_seen && st == ST_OK) begin
          if (pos >= TOTAL_BITS) begin
            st = ST_PAST_END;
          end else begin
            one_seen = stream_bit(pos, missing);
            pos++;
            if (one_seen !== 1'b1) begin
              one_seen = 1'b0;
              zeros++;
              if (zeros > int'(UE_MAX_ZEROS)) st = ST_LONG_PREFIX;
            end
          end
        end
        if (st == ST_OK && pos + zeros > TOTAL_BITS) st = ST_PAST_END;
        if (st == ST_OK) begin
          for (i = 0; i < zeros; i++) begin
            val = {val[VALUE_W-2:0], stream_bit(pos, missing)};
            pos++;
          end
          val = val + ((33'd1 << zeros) - 33'd1);
          // se: odd codes positive, even codes negative
          if (r.action == ACT_SE) begin
            mag = (val + 33'd1) >> 1;
            val = val[0] ? mag : -mag;
          end
        end
      end
      default: return 1'b0;
    endcase
    // any fault leaves the value zero and the cursor in place
    if (st != ST_OK) begin
      val = '0;
      pos = start;
    end
    if (commit) begin
      cur_byte_q = CURSOR_W'(pos >> 3);
      cur_bit_q  = BIT_W'(pos & 7);
    end
    res.field_value = val;
    res.status      = st;
    res.cursor_byte = CURSOR_W'(pos >> 3);
    res.cursor_bit  = BIT_W'(pos & 7);
    return 1'b1;
  endfunction

  function automatic request_t write_req(input int idx, input logic [BYTE_W-1:0] value);
    request_t r;
    r.action     = ACT_WRITE;
    r.byte_index = INDEX_W'(idx);
    r.byte_value = value;
    r.bit_index  = BIT_W'($urandom);
    r.bit_count  = COUNT_W'($urandom);
    return r;
  endfunction

  // Offers one request until taken, then records what it should produce
  task automatic drive_request(input request_t r, input bit typed, input field_result_t typed_res);
    field_result_t predicted;
    int missing;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.action     <= r.action;
    req_if.byte_index <= r.byte_index;
    req_if.byte_value <= r.byte_value;
    req_if.bit_index  <= r.bit_index;
    req_if.bit_count  <= r.bit_count;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    if (decode_request(r, 1'b1, predicted, missing))
      pending_fields.push_back(typed ? typed_res : predicted);
    if (r.action <= ACT_SE) items_sent++;
  endtask

  // Writes every byte a read would touch that holds no data yet, then sends it
  task automatic send_item(input request_t r, input bit typed, input field_result_t typed_res);
    field_result_t scratch;
    int missing;
    forever begin
      void'(decode_request(r, 1'b0, scratch, missing));
      if (missing < 0) break;
      drive_request(write_req(missing, BYTE_W'($urandom)), 1'b0, NO_RESULT);
    end
    drive_request(r, typed, typed_res);
  endtask

  // Encodes a run of fields into the buffer, points the cursor at it, reads them back
  task automatic run_segment();
    bit       code_bits [$];
    request_t reads [$];
    request_t r;
    logic [BYTE_W-1:0] b;
    int lead, nfields, pick, z, n, nbytes, base, i, j;
    lead = $urandom_range(0, 7);
    repeat (lead) code_bits.push_back(1'($urandom_range(0, 1)));
    nfields = $urandom_range(1, 8);
    for (i = 0; i < nfields; i++) begin
      r.byte_index = INDEX_W'($urandom);
      r.byte_value = BYTE_W'($urandom);
      r.bit_index  = BIT_W'($urandom);
      r.bit_count  = COUNT_W'($urandom_range(0, 63));
      pick = $urandom_range(0, 2);
      r.action = (pick == 0) ? ACT_FIXED : (pick == 1) ? ACT_UE : ACT_SE;
      if (r.action == ACT_FIXED) begin
        n = (r.bit_count > MAX_FIELD_BITS) ? int'(MAX_FIELD_BITS) : int'(r.bit_count);
        repeat (n) code_bits.push_back(1'($urandom_range(0, 1)));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) z = $urandom_range(0, 5);
        else if (pick < 95) z = $urandom_range(6, 31);
        else z = 32;
        repeat (z) code_bits.push_back(1'b0);
        code_bits.push_back(1'b1);
        if (z < 32) repeat (z) code_bits.push_back(1'($urandom_range(0, 1)));
      end
      reads.push_back(r);
    end
    while (code_bits.size() % 8 != 0) code_bits.push_back(1'($urandom_range(0, 1)));
    nbytes = code_bits.size() / 8;
    // now and then the run is cut off by the buffer end
    if ($urandom_range(0, 9) == 0) base = BUF_BYTES - $urandom_range(1, nbytes);
    else base = $urandom_range(0, BUF_BYTES - nbytes);
    for (i = 0; i < nbytes && base + i < BUF_BYTES; i++) begin
      for (j = 0; j < 8; j++) b = {b[BYTE_W-2:0], code_bits[8 * i + j]};
      send_item(write_req(base + i, b), 1'b0, NO_RESULT);
    end
    r.action     = ACT_SET;
    r.byte_index = INDEX_W'(base);
    r.bit_index  = BIT_W'(lead);
    r.byte_value = BYTE_W'($urandom);
    r.bit_count  = COUNT_W'($urandom);
    send_item(r, 1'b0, NO_RESULT);
    foreach (reads[k]) send_item(reads[k], 1'b0, NO_RESULT);
  endtask

  // Unstructured requests, unknown actions included
  task automatic run_noise();
    request_t r;
    repeat ($urandom_range(3, 12)) begin
      r.action = ACTION_W'($urandom_range(0, 7));
      if ($urandom_range(0, 4) == 0)
        r.byte_index = INDEX_W'($urandom_range(BUF_BYTES - 8, BUF_BYTES - 1));
      else r.byte_index = INDEX_W'($urandom);
      r.byte_value = BYTE_W'($urandom);
      r.bit_index  = BIT_W'($urandom);
      r.bit_count  = COUNT_W'($urandom_range(0, 63));
      send_item(r, 1'b0, NO_RESULT);
    end
  endtask

  // Result side: random stalls, one long hold-off on request, in-order checking
  initial begin
    field_result_t want;
    forever begin
      @(posedge clk_i);
      if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
        if (pending_fields.size() == 0) begin
          $error("unexpected result: field_value %0d status %0d",
                 res_if.field_value, res_if.status);
          mismatch_count++;
        end else begin
          want = pending_fields.pop_front();
          if (res_if.field_value !== want.field_value) begin
            $error("field_value: expected %0d, got %0d", want.field_value, res_if.field_value);
            mismatch_count++;
          end
          if (res_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_if.status);
            mismatch_count++;
          end
          if (res_if.cursor_byte !== want.cursor_byte) begin
            $error("cursor_byte: expected %0d, got %0d", want.cursor_byte, res_if.cursor_byte);
            mismatch_count++;
          end
          if (res_if.cursor_bit !== want.cursor_bit) begin
            $error("cursor_bit: expected %0d, got %0d", want.cursor_bit, res_if.cursor_bit);
            mismatch_count++;
          end
        end
      end
      if (sink_hold_left > 0) begin
        res_if.ready <= 1'b0;
        sink_hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  // Watchdog
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Reset, directed table, random phases, drain
  initial begin
    int  phase;
    bit  hold_done;
    hold_done = 1'b0;
    req_if.valid      <= 1'b0;
    req_if.action     <= ACT_WRITE;
    req_if.byte_index <= '0;
    req_if.byte_value <= '0;
    req_if.bit_index  <= '0;
    req_if.bit_count  <= '0;
    res_if.ready      <= 1'b0;
    rst_ni            <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int row = 0; row < $size(DIRECTED_ROWS); row++)
      send_item(DIRECTED_ROWS[row].req, DIRECTED_ROWS[row].typed, DIRECTED_ROWS[row].want);

    while (items_sent < ITEM_GOAL) begin
      phase = (items_sent / 100) % 4;
      src_idle_pct   = PHASE_IDLE[phase];
      sink_stall_pct = PHASE_STALL[phase];
      // long receiver hold-off while requests keep coming, so the block backs up
      if (!hold_done && items_sent >= 400) begin
        sink_hold_left = 500;
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 3) != 0) run_segment();
      else run_noise();
    end
    req_if.valid <= 1'b0;

    while (pending_fields.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
